>>> hdl/bomd_pkg.sv
package bomd_pkg;

    localparam int unsigned DWELL_BITS   = 24;
    localparam int unsigned DUTY_BITS    = 8;
    localparam int unsigned CFG_IDX_BITS = 3;

    localparam logic [DWELL_BITS-1:0] MIN_DWELL_RESET = 24'd150000;
    localparam logic [DWELL_BITS-1:0] MAX_DWELL_RESET = 24'd1250000;
    localparam logic [DWELL_BITS-1:0] HOLD_RESET      = 24'd100000;

    localparam logic [DWELL_BITS-1:0] LOCKOUT_US  = 24'd5000;
    localparam logic [DWELL_BITS-1:0] FAST_REV_US = 24'd500000;

    typedef logic signed [8:0] ovr_duty_t;
    typedef logic signed [9:0] duty_t;
    typedef logic [DUTY_BITS-1:0] pwm_t;

    localparam duty_t DUTY_FULL       = 10'sd255;
    localparam duty_t DUTY_INTAKE_OBJ = 10'sd12;
    localparam duty_t DUTY_CONV_OBJ   = -10'sd25;
    localparam duty_t DUTY_CONV_FAST  = -10'sd127;
    localparam duty_t DUTY_ZERO       = 10'sd0;
    localparam duty_t DUTY_NEG_FULL   = -10'sd255;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ENABLE            = 3'd0,
        CFG_OVERRIDE_ON       = 3'd1,
        CFG_OVERRIDE_INTAKE   = 3'd2,
        CFG_OVERRIDE_CONVEYOR = 3'd3,
        CFG_OVERRIDE_RAMP     = 3'd4,
        CFG_MIN_DWELL         = 3'd5,
        CFG_MAX_DWELL         = 3'd6,
        CFG_HOLD              = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic object_present;
        logic score_pulse;
        logic laser_on;
        pwm_t intake_duty;
        pwm_t conveyor_fwd_duty;
        pwm_t conveyor_bwd_duty;
        pwm_t ramp_fwd_duty;
        pwm_t ramp_bwd_duty;
    } result_t;

    function automatic duty_t sat_duty(input ovr_duty_t v);
        duty_t r;
        r = duty_t'(v);
        if (r < DUTY_NEG_FULL)
        begin
            r = DUTY_NEG_FULL;
        end
        return r;
    endfunction

    function automatic pwm_t fwd_part(input duty_t d);
        return (d > DUTY_ZERO) ? d[DUTY_BITS-1:0] : '0;
    endfunction

    function automatic pwm_t bwd_part(input duty_t d);
        duty_t n;
        n = -d;
        return (d > DUTY_ZERO) ? '0 : n[DUTY_BITS-1:0];
    endfunction

endpackage

>>> hdl/beam_object_qualifier_motor_drive_top.sv
// Qualifies a raw beam-break bit against min/max dwell, an exit lockout and a
// hold time, flags a score on each new object, and sets the three motor duties.
// One item is taken per clock cycle while the output is not stalled, and its
// result passes through the input register and then the result register.
// The qualification state is read and rewritten as each item advances, so
// consecutive items see each other's effect with no stall.
module beam_object_qualifier_motor_drive_top #(
    parameter int TIME_BITS = 48
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // Bit 0: raw_detect; bits 48:1: now_us; bits 55:49: zero.
    input  logic [55:0]                           s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // Bit 0: object_present; 1: score_pulse; 2: laser_on; 10:3: intake_duty;
    // 18:11: conveyor_fwd_duty; 26:19: conveyor_bwd_duty; 34:27: ramp_fwd_duty;
    // 42:35: ramp_bwd_duty; 47:43: zero.
    output logic [47:0]                           m_axis_tdata,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [bomd_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [bomd_pkg::DWELL_BITS-1:0]       cfg_data
);
    import bomd_pkg::*;

    typedef logic [TIME_BITS-1:0] tick_t;

    logic                  enable_reg;
    logic                  override_on_reg;
    ovr_duty_t             ovr_intake_reg;
    ovr_duty_t             ovr_conveyor_reg;
    ovr_duty_t             ovr_ramp_reg;
    logic [DWELL_BITS-1:0] min_dwell_reg;
    logic [DWELL_BITS-1:0] max_dwell_reg;
    logic [DWELL_BITS-1:0] hold_reg;

    tick_t entry_reg;
    tick_t last_valid_reg;
    tick_t exit_reg;
    logic  had_object_reg;

    logic    in_valid_reg;
    logic    in_det_reg;
    tick_t   in_now_reg;
    logic    out_valid_reg;
    result_t out_reg;

    logic    advance;
    tick_t   entry_a;
    tick_t   el_a;
    tick_t   el_b;
    tick_t   el_exit;
    tick_t   el_last;
    logic    new_entry;
    logic    det1;
    logic    det2;
    logic    det3;
    logic    lockout;
    logic    has;
    tick_t   entry_next;
    tick_t   exit_next;
    tick_t   last_valid_next;
    duty_t   di;
    duty_t   dc;
    duty_t   dr;
    result_t res_next;

    assign cfg_ready     = 1'b1;
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_reg.ramp_bwd_duty, out_reg.ramp_fwd_duty,
                            out_reg.conveyor_bwd_duty, out_reg.conveyor_fwd_duty,
                            out_reg.intake_duty, out_reg.laser_on,
                            out_reg.score_pulse, out_reg.object_present};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg       <= 1'b0;
            override_on_reg  <= 1'b0;
            ovr_intake_reg   <= '0;
            ovr_conveyor_reg <= '0;
            ovr_ramp_reg     <= '0;
            min_dwell_reg    <= MIN_DWELL_RESET;
            max_dwell_reg    <= MAX_DWELL_RESET;
            hold_reg         <= HOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ENABLE:            enable_reg       <= cfg_data[0];
                CFG_OVERRIDE_ON:       override_on_reg  <= cfg_data[0];
                CFG_OVERRIDE_INTAKE:   ovr_intake_reg   <= cfg_data[8:0];
                CFG_OVERRIDE_CONVEYOR: ovr_conveyor_reg <= cfg_data[8:0];
                CFG_OVERRIDE_RAMP:     ovr_ramp_reg     <= cfg_data[8:0];
                CFG_MIN_DWELL:         min_dwell_reg    <= cfg_data;
                CFG_MAX_DWELL:         max_dwell_reg    <= cfg_data;
                CFG_HOLD:              hold_reg         <= cfg_data;
                default:               ;
            endcase
        end
    end

    // Qualification chain for the item held in the input register.
    always_comb
    begin
        entry_a   = in_det_reg ? entry_reg : '0;
        el_a      = in_now_reg - entry_a;
        det1      = in_det_reg && !((entry_a != '0) && (el_a > tick_t'(max_dwell_reg)));
        new_entry = det1 && (entry_a == '0);
        entry_next = new_entry ? in_now_reg : entry_a;
        el_b      = new_entry ? '0 : el_a;
        det2      = det1 && !((entry_next != '0) && (el_b < tick_t'(min_dwell_reg)));
        el_exit   = in_now_reg - exit_reg;
        lockout   = det2 && (exit_reg != '0) && (el_exit < tick_t'(LOCKOUT_US));
        det3      = det2 && !lockout;
        last_valid_next = det3 ? in_now_reg : last_valid_reg;
        el_last   = det3 ? '0 : (in_now_reg - last_valid_reg);
        has       = (last_valid_next != '0) && (el_last < tick_t'(hold_reg));
        if (had_object_reg && !has)
        begin
            exit_next = in_now_reg;
        end
        else if (lockout)
        begin
            exit_next = in_now_reg;
        end
        else
        begin
            exit_next = exit_reg;
        end

        if (override_on_reg)
        begin
            di = sat_duty(ovr_intake_reg);
            dc = sat_duty(ovr_conveyor_reg);
            dr = sat_duty(ovr_ramp_reg);
        end
        else if (!enable_reg)
        begin
            di = DUTY_ZERO;
            dc = DUTY_ZERO;
            dr = DUTY_ZERO;
        end
        else if (has)
        begin
            di = DUTY_INTAKE_OBJ;
            dc = (el_b < tick_t'(FAST_REV_US)) ? DUTY_CONV_FAST : DUTY_CONV_OBJ;
            dr = DUTY_FULL;
        end
        else
        begin
            di = DUTY_FULL;
            dc = DUTY_FULL;
            dr = DUTY_FULL;
        end

        res_next.object_present    = has;
        res_next.score_pulse       = has && !had_object_reg;
        res_next.laser_on          = enable_reg;
        res_next.intake_duty       = fwd_part(di);
        res_next.conveyor_fwd_duty = fwd_part(dc);
        res_next.conveyor_bwd_duty = bwd_part(dc);
        res_next.ramp_fwd_duty     = fwd_part(dr);
        res_next.ramp_bwd_duty     = bwd_part(dr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg      <= '0;
            last_valid_reg <= '0;
            exit_reg       <= '0;
            had_object_reg <= 1'b0;
        end
        else if (advance)
        begin
            entry_reg      <= entry_next;
            last_valid_reg <= last_valid_next;
            exit_reg       <= exit_next;
            had_object_reg <= has;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_det_reg <= s_axis_tdata[0];
            in_now_reg <= tick_t'(s_axis_tdata[48:1]);
        end
        if (advance)
        begin
            out_reg <= res_next;
        end
    end

endmodule

>>> sim/tb_top.sv
module tb_top;
    import bomd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;

    class qualifier_scoreboard;
        logic                   enabled;
        logic                   override_on;
        logic signed [8:0]      ovr_intake;
        logic signed [8:0]      ovr_conveyor;
        logic signed [8:0]      ovr_ramp;
        logic [DWELL_BITS-1:0]  min_dwell;
        logic [DWELL_BITS-1:0]  max_dwell;
        logic [DWELL_BITS-1:0]  hold_time;

        logic [47:0]            entered_at;
        logic [47:0]            last_seen_at;
        logic [47:0]            cleared_at;
        logic                   present;

        result_t                pending_readouts[$];
        int unsigned            checked;
        int unsigned            mismatches;
        int unsigned            pulses;
        int unsigned            lockouts;
        int unsigned            overstays;

        function new();
            enabled = 1'b0;
            override_on = 1'b0;
            ovr_intake = '0;
            ovr_conveyor = '0;
            ovr_ramp = '0;
            min_dwell = MIN_DWELL_RESET;
            max_dwell = MAX_DWELL_RESET;
            hold_time = HOLD_RESET;
            entered_at = '0;
            last_seen_at = '0;
            cleared_at = '0;
            present = 1'b0;
            checked = 0;
            mismatches = 0;
            pulses = 0;
            lockouts = 0;
            overstays = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [DWELL_BITS-1:0] d);
            case (idx)
                CFG_ENABLE:            enabled = d[0];
                CFG_OVERRIDE_ON:       override_on = d[0];
                CFG_OVERRIDE_INTAKE:   ovr_intake = d[8:0];
                CFG_OVERRIDE_CONVEYOR: ovr_conveyor = d[8:0];
                CFG_OVERRIDE_RAMP:     ovr_ramp = d[8:0];
                CFG_MIN_DWELL:         min_dwell = d;
                CFG_MAX_DWELL:         max_dwell = d;
                CFG_HOLD:              hold_time = d;
                default:               ;
            endcase
        endfunction

        function logic [47:0] since(logic [47:0] now, logic [47:0] stamp);
            return now - stamp;
        endfunction

        function int clip(logic signed [8:0] v);
            int x;
            x = int'(v);
            if (x < -255)
            begin
                x = -255;
            end
            return x;
        endfunction

        // Signed-magnitude split: {bwd, fwd}.
        function logic [15:0] split(int duty);
            if (duty > 0)
            begin
                return {8'd0, duty[7:0]};
            end
            duty = -duty;
            return {duty[7:0], 8'd0};
        endfunction

        function void qualify_sample(logic raw, logic [47:0] now);
            result_t r;
            logic    hit;
            logic    has;
            int      di;
            int      dc;
            int      dr;
            hit = raw;
            if (!hit)
            begin
                entered_at = '0;
            end
            if (hit && entered_at != '0 && since(now, entered_at) > 48'(max_dwell))
            begin
                hit = 1'b0;
                overstays++;
            end
            if (hit && entered_at == '0)
            begin
                entered_at = now;
            end
            if (hit && entered_at != '0 && since(now, entered_at) < 48'(min_dwell))
            begin
                hit = 1'b0;
            end
            if (hit && cleared_at != '0 && since(now, cleared_at) < 48'(LOCKOUT_US))
            begin
                hit = 1'b0;
                cleared_at = now;
                lockouts++;
            end
            if (hit)
            begin
                last_seen_at = now;
            end

            has = last_seen_at != '0 && since(now, last_seen_at) < 48'(hold_time);
            r.object_present = has;
            r.score_pulse = !present && has;
            if (present && !has)
            begin
                cleared_at = now;
            end
            present = has;

            if (override_on)
            begin
                di = clip(ovr_intake);
                dc = clip(ovr_conveyor);
                dr = clip(ovr_ramp);
            end
            else if (!enabled)
            begin
                di = 0;
                dc = 0;
                dr = 0;
            end
            else if (has)
            begin
                di = int'(DUTY_INTAKE_OBJ);
                dc = int'(DUTY_CONV_OBJ);
                dr = int'(DUTY_FULL);
                if (since(now, entered_at) < 48'(FAST_REV_US))
                begin
                    dc = int'(DUTY_CONV_FAST);
                end
            end
            else
            begin
                di = int'(DUTY_FULL);
                dc = int'(DUTY_FULL);
                dr = int'(DUTY_FULL);
            end

            r.laser_on = enabled;
            r.intake_duty = (di > 0) ? di[7:0] : 8'd0;
            {r.conveyor_bwd_duty, r.conveyor_fwd_duty} = split(dc);
            {r.ramp_bwd_duty, r.ramp_fwd_duty} = split(dr);
            pending_readouts.push_back(r);
        endfunction

        function void field_check(string what, int want, int got);
            if (want != got)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("Mismatch on result %0d, %s: expected %0d, got %0d",
                             checked, what, want, got);
                end
            end
        endfunction

        function void compare_readout(logic [47:0] d);
            result_t e;
            if (pending_readouts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("Unexpected result with no sample waiting: %h", d);
                end
                return;
            end
            e = pending_readouts.pop_front();
            checked++;
            if (e.score_pulse)
            begin
                pulses++;
            end
            field_check("object_present", int'(e.object_present), int'(d[0]));
            field_check("score_pulse", int'(e.score_pulse), int'(d[1]));
            field_check("laser_on", int'(e.laser_on), int'(d[2]));
            field_check("intake_duty", int'(e.intake_duty), int'(d[10:3]));
            field_check("conveyor_fwd_duty", int'(e.conveyor_fwd_duty), int'(d[18:11]));
            field_check("conveyor_bwd_duty", int'(e.conveyor_bwd_duty), int'(d[26:19]));
            field_check("ramp_fwd_duty", int'(e.ramp_fwd_duty), int'(d[34:27]));
            field_check("ramp_bwd_duty", int'(e.ramp_bwd_duty), int'(d[42:35]));
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [55:0]             s_axis_tdata;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [47:0]             m_axis_tdata;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [DWELL_BITS-1:0]   cfg_data;

    qualifier_scoreboard sb = new();
    bit                  steady;
    logic [47:0]         stamp;
    int unsigned         sent;
    int unsigned         settings;
    int unsigned         cycles;

    beam_object_qualifier_motor_drive_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycles, sb.pending_readouts.size());
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sb.compare_readout(m_axis_tdata);
        end
    end

    // The receiver stalls at random, and once holds off for a long stretch
    // so that the block backs up into its input.
    initial
    begin
        int unsigned hold_left;
        bit          held;
        hold_left = 0;
        held = 1'b0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && sb.checked >= 600)
            begin
                held = 1'b1;
                hold_left = 400;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= steady || ($urandom_range(0, 99) >= 28);
            end
        end
    end

    task automatic send_sample(logic raw, logic [47:0] now);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 28)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, now, raw};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        sb.qualify_sample(raw, now);
        sent++;
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [DWELL_BITS-1:0] d);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        sb.set_reg(idx, d);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending_readouts.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Unused upper bits of the written data are filled with noise.
    task automatic retune(bit en, bit ovr, logic [23:0] mn, logic [23:0] mx,
                          logic [23:0] hd);
        logic [23:0] junk;
        settle();
        junk = 24'($urandom);
        write_reg(CFG_ENABLE, {junk[23:1], en});
        write_reg(CFG_OVERRIDE_ON, {junk[22:0], ovr});
        junk = 24'($urandom);
        write_reg(CFG_OVERRIDE_INTAKE, junk);
        junk = 24'($urandom);
        write_reg(CFG_OVERRIDE_CONVEYOR, junk);
        junk = 24'($urandom);
        write_reg(CFG_OVERRIDE_RAMP, junk);
        write_reg(CFG_MIN_DWELL, mn);
        write_reg(CFG_MAX_DWELL, mx);
        write_reg(CFG_HOLD, hd);
        settings++;
    endtask

    // Mostly blocked/clear passes with random step sizes, plus single noisy
    // samples and occasional large jumps in time.
    task automatic run_traffic(int unsigned count, int unsigned span);
        int unsigned left;
        int unsigned run;
        int unsigned k;
        int unsigned pick;
        logic        level;
        left = count;
        while (left != 0)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
            begin
                for (k = 0; k < 2 && left != 0; k++)
                begin
                    level = (k == 0);
                    run = level ? $urandom_range(1, 40) : $urandom_range(1, 12);
                    while (run != 0 && left != 0)
                    begin
                        stamp += 48'($urandom_range(0, span));
                        send_sample(level, stamp);
                        run--;
                        left--;
                    end
                end
            end
            else
            begin
                if (pick < 92)
                begin
                    stamp += 48'($urandom_range(0, span));
                end
                else
                begin
                    stamp += 48'($urandom) << $urandom_range(0, 16);
                end
                send_sample(1'($urandom), stamp);
                left--;
            end
        end
    endtask

    initial
    begin
        logic [23:0] mn;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_ENABLE;
        cfg_data = '0;
        steady = 1'b0;
        stamp = '0;
        sent = 0;
        settings = 1;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Default dwell settings: zero timestamp, min dwell, fast reverse
        // with the beam already cleared, hold expiry and max dwell.
        write_reg(CFG_ENABLE, 24'd1);
        send_sample(1'b1, 48'd0);
        send_sample(1'b1, 48'd100);
        send_sample(1'b1, 48'd150100);
        send_sample(1'b0, 48'd200000);
        send_sample(1'b0, 48'd260000);
        send_sample(1'b1, 48'd400000);
        send_sample(1'b1, 48'd560000);
        send_sample(1'b1, 48'd1650001);
        send_sample(1'b0, 48'd1700000);

        // Exit lockout and its restart, then timestamp wraparound.
        settle();
        write_reg(CFG_MIN_DWELL, 24'd0);
        write_reg(CFG_MAX_DWELL, 24'd20000);
        write_reg(CFG_HOLD, 24'd1000);
        settings++;
        send_sample(1'b1, 48'd2000000);
        send_sample(1'b0, 48'd2000500);
        send_sample(1'b0, 48'd2001500);
        send_sample(1'b1, 48'd2003000);
        send_sample(1'b1, 48'd2007000);
        send_sample(1'b1, 48'd2012500);
        send_sample(1'b1, 48'd2040000);
        send_sample(1'b0, 48'hFFFF_FFFF_FFF0);
        send_sample(1'b1, 48'hFFFF_FFFF_FFF8);
        send_sample(1'b1, 48'h0000_0000_0100);

        // Override duties, including saturation and the intake reverse case.
        settle();
        write_reg(CFG_OVERRIDE_ON, 24'd1);
        write_reg(CFG_ENABLE, 24'd0);
        write_reg(CFG_OVERRIDE_INTAKE, 24'h000100);
        write_reg(CFG_OVERRIDE_CONVEYOR, 24'h0000FF);
        write_reg(CFG_OVERRIDE_RAMP, 24'h000101);
        settings++;
        send_sample(1'b1, 48'h0000_0000_0200);
        send_sample(1'b0, 48'h0000_0000_0300);
        settle();
        write_reg(CFG_OVERRIDE_INTAKE, 24'hFFFEFF);
        write_reg(CFG_OVERRIDE_CONVEYOR, 24'h000100);
        write_reg(CFG_OVERRIDE_RAMP, 24'h000000);
        settings++;
        send_sample(1'b1, 48'h0000_0000_0400);
        send_sample(1'b1, 48'h0000_0000_0500);
        stamp = 48'h0000_0000_0500;

        mn = 24'($urandom_range(0, 6000));
        retune(1'b1, 1'b0, mn, 24'(mn + $urandom_range(0, 20000)),
               24'($urandom_range(0, 8000)));
        run_traffic(180, 2000);

        mn = 24'($urandom_range(0, 600));
        retune(1'b1, 1'b0, mn, 24'(mn + $urandom_range(0, 2000)),
               24'($urandom_range(0, 800)));
        steady = 1'b1;
        run_traffic(180, 200);
        steady = 1'b0;

        retune(1'b1, 1'b0, MIN_DWELL_RESET, MAX_DWELL_RESET, HOLD_RESET);
        run_traffic(180, 20000);

        retune(1'b1, 1'b0, 24'd0, 24'd0, 24'hFFFFFF);
        run_traffic(180, 2000);

        retune(1'b1, 1'b0, 24'hFFFFFF, 24'hFFFFFF, 24'd0);
        run_traffic(180, 1000000);

        mn = 24'($urandom_range(0, 6000));
        retune(1'b0, 1'b0, mn, 24'(mn + $urandom_range(0, 20000)),
               24'($urandom_range(0, 8000)));
        run_traffic(180, 2000);

        mn = 24'($urandom_range(0, 6000));
        retune(1'($urandom), 1'b1, mn, 24'(mn + $urandom_range(0, 20000)),
               24'($urandom_range(0, 8000)));
        run_traffic(180, 2000);

        mn = 24'($urandom_range(0, 60000));
        retune(1'b1, 1'b0, mn, 24'(mn + $urandom_range(0, 200000)),
               24'($urandom_range(0, 40000)));
        run_traffic(180, 20000);

        settle();
        $display("Run covered %0d samples under %0d register settings, %0d score pulses,",
                 sent, settings, sb.pulses);
        $display("%0d lockout rejections and %0d max dwell drops; %0d results checked.",
                 sb.lockouts, sb.overstays, sb.checked);
        if (sb.mismatches == 0 && sb.pending_readouts.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("%0d mismatches, %0d results never arrived",
                     sb.mismatches, sb.pending_readouts.size());
            $display("FAILURE");
        end
        $finish;
    end

endmodule
